FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);

`endif

FILE: hw/rtl/daut_pkg.sv
// ----------------------------------------------------------------------------
// daut_pkg
// Types and constants for the device address table: operation codes, the
// request and response payloads and the entry memory word.
// ----------------------------------------------------------------------------
package daut_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned SigW   = 8;
  localparam int unsigned QidxW  = 5;
  localparam int unsigned CountW = 6;

  // operation codes
  localparam logic [1:0] FuncUpsert = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncClear  = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [AddrW-1:0]        dev_addr;
    logic signed [SigW-1:0]  signal_dbm;
    logic [QidxW-1:0]        query_index;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]        addr;
    logic signed [SigW-1:0]  signal;
  } entry_t;

  typedef struct packed {
    logic                    found;
    entry_t                  entry;
    logic [CountW-1:0]       count;
  } rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctrl_t;

endpackage

FILE: hw/rtl/daut_if.sv
// ----------------------------------------------------------------------------
// daut_if
// Valid/ready channels of the device address table: request and response.
// ----------------------------------------------------------------------------
interface daut_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [47:0]       dev_addr;
  logic signed [7:0] signal_dbm;
  logic [4:0]        query_index;

  modport source (output valid, func, dev_addr, signal_dbm, query_index, input ready);
  modport sink   (input valid, func, dev_addr, signal_dbm, query_index, output ready);
endinterface

interface daut_rsp_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [47:0]       entry_addr;
  logic signed [7:0] entry_signal;
  logic [5:0]        entry_count;

  modport source (output valid, found, entry_addr, entry_signal, entry_count, input ready);
  modport sink   (input valid, found, entry_addr, entry_signal, entry_count, output ready);
endinterface

FILE: hw/rtl/daut_entry_ram.sv
// ----------------------------------------------------------------------------
// daut_entry_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module daut_entry_ram import daut_pkg::*; #(
  parameter int unsigned ENTRIES = 32,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk_i,
  input  ram_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/daut_scan_ctrl.sv
// ----------------------------------------------------------------------------
// daut_scan_ctrl
// Sequencer that walks the entry memory one slot per cycle, keeps the valid
// bits and the count, and decides the write-back of an upsert.
// ----------------------------------------------------------------------------
module daut_scan_ctrl import daut_pkg::*; #(
  parameter int unsigned ENTRIES = 32,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  req_t            req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output rsp_t            res_o,
  output ram_ctrl_t       ram_ctrl_o,
  output logic [IdxW-1:0] ram_waddr_o,
  output entry_t          ram_wdata_o,
  output logic [IdxW-1:0] ram_raddr_o,
  input  entry_t          ram_rdata_i
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > QidxW) ? CntW : QidxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]         state_q, state_d;
  req_t               op_q;
  logic [IdxW-1:0]    cmp_idx_q;
  logic [CntW-1:0]    seen_q;
  logic               free_found_q;
  logic [IdxW-1:0]    free_idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CntW-1:0]    count_q;
  logic               res_found_q;
  entry_t             res_entry_q;

  logic accept;
  logic scanning;
  logic slot_valid;
  logic last_slot;
  logic addr_hit;
  logic ord_hit;
  logic is_upsert;
  logic is_query;
  logic claim_ok;
  logic [IdxW-1:0] claim_idx;
  logic scan_done;
  logic claim;
  logic capture;

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;
  assign scanning    = (state_q == StScan);

  // slot under comparison: read data of cmp_idx_q is on the port this cycle
  assign slot_valid = valid_q[cmp_idx_q];
  assign last_slot  = (cmp_idx_q == LastIdx);
  assign addr_hit   = slot_valid && (ram_rdata_i.addr == op_q.dev_addr);
  assign ord_hit    = slot_valid && (CmpW'(seen_q) == CmpW'(op_q.query_index));
  assign is_upsert  = (op_q.func == FuncUpsert);
  assign is_query   = (op_q.func == FuncQuery);

  // lowest free slot seen so far, this one included
  assign claim_ok  = free_found_q || !slot_valid;
  assign claim_idx = free_found_q ? free_idx_q : cmp_idx_q;

  // scan decisions and memory access
  always_comb begin
    scan_done   = 1'b0;
    claim       = 1'b0;
    capture     = 1'b0;
    ram_ctrl_o  = '0;
    ram_waddr_o = cmp_idx_q;
    ram_wdata_o = '{addr: op_q.dev_addr, signal: op_q.signal_dbm};
    ram_raddr_o = '0;
    if (accept) begin
      ram_ctrl_o.re = 1'b1;
    end else if (scanning) begin
      if (is_upsert) begin
        if (addr_hit) begin
          scan_done     = 1'b1;
          ram_ctrl_o.we = 1'b1;
        end else if (last_slot) begin
          scan_done = 1'b1;
          if (claim_ok) begin
            claim         = 1'b1;
            ram_ctrl_o.we = 1'b1;
            ram_waddr_o   = claim_idx;
          end
        end
      end else begin
        if (ord_hit) begin
          scan_done = 1'b1;
          capture   = 1'b1;
        end else if (last_slot) begin
          scan_done = 1'b1;
        end
      end
      if (!scan_done) begin
        ram_ctrl_o.re = 1'b1;
        ram_raddr_o   = last_slot ? '0 : cmp_idx_q + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.func == FuncUpsert || req_i.func == FuncQuery) begin
            state_d = StScan;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        if (scan_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state: fsm, valid bits, count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept && req_i.func == FuncClear) begin
        valid_q <= '0;
        count_q <= '0;
      end else if (claim) begin
        valid_q[claim_idx] <= 1'b1;
        count_q            <= count_q + 1'b1;
      end
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= req_i;
      cmp_idx_q    <= '0;
      seen_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      res_found_q  <= 1'b0;
      res_entry_q  <= '0;
    end else if (scanning) begin
      cmp_idx_q <= cmp_idx_q + 1'b1;
      if (is_upsert && !slot_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      if (is_query && slot_valid) begin
        seen_q <= seen_q + 1'b1;
      end
      if (capture) begin
        res_found_q <= 1'b1;
        res_entry_q <= ram_rdata_i;
      end
    end
  end

  assign res_valid_o = (state_q == StFinish);
  assign res_o       = '{found: res_found_q, entry: res_entry_q, count: CountW'(count_q)};

endmodule

FILE: hw/rtl/device_address_upsert_table_core.sv
// ----------------------------------------------------------------------------
// device_address_upsert_table_core
// Table of discovered devices keyed by 48-bit address: upsert, query, clear.
// ----------------------------------------------------------------------------
// The block handles one item at a time. An upsert or a query walks the slots
// in order through the single read port of the entry memory, one slot per
// cycle, and stops at the matching slot; a clear or an unused code goes
// straight to the result without a walk. A result waits in the output
// register while the next request is taken. Valid bits live in flip-flops
// and are cleared at reset and by a clear item, so there is no clearing
// pass. entry_count reports the low 6 bits of the number of valid slots
// after the item.
module device_address_upsert_table_core import daut_pkg::*; #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  daut_req_if.sink       req_i,
  daut_rsp_if.source     rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            req_valid;
  logic            req_ready;
  req_t            req;
  logic            res_valid;
  logic            res_ready;
  rsp_t            res;
  logic            rsp_valid_q;
  logic            rsp_ready;
  rsp_t            rsp_q;
  ram_ctrl_t       ram_ctrl;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  // request channel
  assign req_valid   = req_i.valid;
  assign req_i.ready = req_ready;
  assign req = '{func: req_i.func, dev_addr: req_i.dev_addr,
                 signal_dbm: req_i.signal_dbm, query_index: req_i.query_index};

  daut_scan_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_ctrl_o  (ram_ctrl),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  daut_entry_ram #(
    .ENTRIES (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .ctrl_i  (ram_ctrl),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign rsp_ready = rsp_o.ready;
  assign res_ready = !rsp_valid_q || rsp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.found        = rsp_q.found;
  assign rsp_o.entry_addr   = rsp_q.entry.addr;
  assign rsp_o.entry_signal = rsp_q.entry.signal;
  assign rsp_o.entry_count  = rsp_q.count;

endmodule

FILE: hw/rtl/daut_checker.sv
// ----------------------------------------------------------------------------
// daut_checker
// Port-level checks on the device address table, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module daut_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_found_i,
  input logic [47:0]       out_addr_i,
  input logic signed [7:0] out_signal_i
);

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped while stalled")

  // one item at a time: no request taken in the cycle after a transfer
  `ASSERT_CLK(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "request taken while an item is in work")

  // a miss or a non-query reports a zero entry
  `ASSERT_NEVER(a_miss_zero, clk_i, rst_ni, out_valid_i && !out_found_i && (out_addr_i != 48'd0 || out_signal_i != 8'sd0), "entry fields set without a hit")

endmodule

bind device_address_upsert_table_core daut_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_valid),
  .in_ready_i   (req_ready),
  .out_valid_i  (rsp_valid_q),
  .out_ready_i  (rsp_ready),
  .out_found_i  (rsp_q.found),
  .out_addr_i   (rsp_q.entry.addr),
  .out_signal_i (rsp_q.entry.signal)
);

FILE: verif/tb_device_address_upsert_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_device_address_upsert_table_core
// Self-checking bench for the device address table. A driver feeds requests
// from a queue and a monitor checks each response, field by field, against a
// mirror of the table that is updated on every request transfer. Directed
// items come first, then random traffic: upserts over a small address pool,
// a full-table fill, a long receiver hold-off and back-to-back stretches.
// ----------------------------------------------------------------------------
module tb_device_address_upsert_table_core;
  import daut_pkg::*;

  localparam int unsigned Entries        = 32;
  localparam int unsigned ClkPeriodNs    = 20;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned TimeoutCycles  = 300_000;
  // code left unused by the block
  localparam logic [1:0]  FuncUnused     = 2'd3;

  logic clk_i;
  logic rst_ni;

  daut_req_if req_if ();
  daut_rsp_if rsp_if ();

  device_address_upsert_table_core #(
    .ENTRIES (Entries)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // mirror of the table contents
  bit                     mirror_valid [Entries];
  logic [AddrW-1:0]       mirror_addr  [Entries];
  logic signed [SigW-1:0] mirror_sig   [Entries];
  int unsigned            mirror_count = 0;

  req_t             reqs_to_send      [$];
  rsp_t             table_results_due [$];
  logic [AddrW-1:0] addr_pool         [$];

  int unsigned error_count     = 0;
  int unsigned reqs_taken      = 0;
  int unsigned results_checked = 0;
  int unsigned full_drops      = 0;
  int unsigned query_hits      = 0;
  int unsigned send_gap        = 0;
  int unsigned hold_left       = 0;
  bit          req_taken       = 1'b0;
  bit          long_hold_req   = 1'b0;
  bit          steady_flow     = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriodNs / 2) clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apply one request to the mirror and work out its response
  function automatic rsp_t table_apply(req_t rq);
    rsp_t        res;
    int          hit;
    int          free_slot;
    int unsigned seen;
    int          i;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    seen      = 0;
    case (rq.func)
      FuncUpsert: begin
        for (i = 0; i < Entries; i++) begin
          if (hit < 0) begin
            if (mirror_valid[i]) begin
              if (mirror_addr[i] == rq.dev_addr) hit = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
        end
        // new address takes the lowest free slot
        if (hit < 0 && free_slot >= 0) begin
          hit               = free_slot;
          mirror_valid[hit] = 1'b1;
          mirror_addr[hit]  = rq.dev_addr;
          mirror_count++;
        end
        if (hit >= 0) begin
          mirror_sig[hit] = rq.signal_dbm;
        end else begin
          full_drops++;
        end
      end
      FuncQuery: begin
        for (i = 0; i < Entries; i++) begin
          if (mirror_valid[i]) begin
            if (!res.found && seen == rq.query_index) begin
              res.found        = 1'b1;
              res.entry.addr   = mirror_addr[i];
              res.entry.signal = mirror_sig[i];
            end
            seen++;
          end
        end
        if (res.found) query_hits++;
      end
      FuncClear: begin
        mirror_valid = '{default: 1'b0};
        mirror_count = 0;
      end
      default: begin
      end
    endcase
    res.count = mirror_count[CountW-1:0];
    return res;
  endfunction

  function automatic logic [AddrW-1:0] fresh_addr();
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    return word[AddrW-1:0];
  endfunction

  function automatic req_t make_req(logic [1:0] func, logic [AddrW-1:0] addr,
                                    logic signed [SigW-1:0] sig, logic [QidxW-1:0] idx);
    req_t rq;
    rq.func        = func;
    rq.dev_addr    = addr;
    rq.signal_dbm  = sig;
    rq.query_index = idx;
    return rq;
  endfunction

  // random request: upserts mostly over the pool, queries biased low
  function automatic req_t random_item(int unsigned pool_cap);
    req_t        rq;
    int unsigned roll;
    rq.func        = FuncQuery;
    rq.dev_addr    = fresh_addr();
    rq.signal_dbm  = SigW'($urandom_range(0, 255));
    rq.query_index = QidxW'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      rq.func = FuncUpsert;
      if (addr_pool.size() > 0 && $urandom_range(0, 99) < 75) begin
        rq.dev_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      end else if (addr_pool.size() < pool_cap) begin
        addr_pool.push_back(rq.dev_addr);
      end
    end else if (roll < 94) begin
      if ($urandom_range(0, 99) < 60) rq.query_index = QidxW'($urandom_range(0, 15));
    end else if (roll < 97) begin
      rq.func = FuncClear;
    end else begin
      rq.func = FuncUnused;
    end
    return rq;
  endfunction

  task automatic wait_drained();
    while (reqs_to_send.size() != 0 || req_if.valid || table_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
    end
  endfunction

  // request driver: a new transfer is offered at the falling edge
  always @(negedge clk_i) begin : req_driver
    req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (req_taken) begin
        req_taken = 1'b0;
        send_gap  = steady_flow ? 0 : pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (reqs_to_send.size() > 0) begin
        nxt = reqs_to_send.pop_front();
        req_if.func        <= nxt.func;
        req_if.dev_addr    <= nxt.dev_addr;
        req_if.signal_dbm  <= nxt.signal_dbm;
        req_if.query_index <= nxt.query_index;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response ready: random holds, plus one long hold on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LongHoldCycles - 1;
      rsp_if.ready <= 1'b0;
    end else if (steady_flow) begin
      rsp_if.ready <= 1'b1;
    end else begin
      hold_left = pick_gap();
      if (hold_left == 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // monitor: check response transfers, then predict from request transfers
  always @(posedge clk_i) begin : table_port_monitor
    rsp_t due;
    req_t taken;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (table_results_due.size() == 0) begin
        error_count++;
        $display("%0t: response with nothing outstanding: expected none, actual %b %h %h %0d",
                 $time, rsp_if.found, rsp_if.entry_addr, rsp_if.entry_signal,
                 rsp_if.entry_count);
      end else begin
        due = table_results_due.pop_front();
        check_field("found", 64'(due.found), 64'(rsp_if.found));
        check_field("entry_addr", 64'(due.entry.addr), 64'(rsp_if.entry_addr));
        check_field("entry_signal", 64'(due.entry.signal), 64'(rsp_if.entry_signal));
        check_field("entry_count", 64'(due.count), 64'(rsp_if.entry_count));
        results_checked++;
      end
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      taken.func        = req_if.func;
      taken.dev_addr    = req_if.dev_addr;
      taken.signal_dbm  = req_if.signal_dbm;
      taken.query_index = req_if.query_index;
      table_results_due.push_back(table_apply(taken));
      reqs_taken++;
      req_taken = 1'b1;
    end
  end

  // run limit
  initial begin
    #(TimeoutCycles * ClkPeriodNs);
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned      n;
    logic [AddrW-1:0] a;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FuncUpsert;
    req_if.dev_addr    = '0;
    req_if.signal_dbm  = '0;
    req_if.query_index = '0;
    rsp_if.ready       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, update in place, past the end,
    // unused code, clear with stale contents
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd0));
    reqs_to_send.push_back(make_req(FuncUpsert, '0,          8'sh80,    5'd0));
    reqs_to_send.push_back(make_req(FuncUpsert, '1,          8'sh7f,    5'd31));
    reqs_to_send.push_back(make_req(FuncUpsert, '0,          8'sh00,    5'd0));
    reqs_to_send.push_back(make_req(FuncQuery,  '1,          8'sh7f,    5'd0));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd1));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd2));
    reqs_to_send.push_back(make_req(FuncQuery,  '1,          8'sh80,    5'd31));
    reqs_to_send.push_back(make_req(FuncUpsert, 48'haaaa_aaaa_aaaa, -8'sd1, 5'd21));
    reqs_to_send.push_back(make_req(FuncUpsert, 48'h5555_5555_5555, 8'sd1,  5'd10));
    reqs_to_send.push_back(make_req(FuncUpsert, '1,          8'sh80,    5'd0));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd3));
    reqs_to_send.push_back(make_req(FuncUnused, '1,          -8'sd1,    5'd31));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd1));
    reqs_to_send.push_back(make_req(FuncClear,  '1,          -8'sd1,    5'd31));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd0));
    reqs_to_send.push_back(make_req(FuncUpsert, 48'h5555_5555_5555, 8'sd85, 5'd0));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd0));
    reqs_to_send.push_back(make_req(FuncUpsert, 48'h0123_4567_89ab, -8'sd50, 5'd0));
    reqs_to_send.push_back(make_req(FuncQuery,  '0,          '0,        5'd1));
    addr_pool.push_back('0);
    addr_pool.push_back('1);
    addr_pool.push_back(48'haaaa_aaaa_aaaa);
    addr_pool.push_back(48'h5555_5555_5555);

    // random mix over a small pool, so that most upserts hit
    for (n = 0; n < 130; n++) reqs_to_send.push_back(random_item(12));

    // fill the table past full, then mixed traffic on a full table
    reqs_to_send.push_back(make_req(FuncClear, '0, '0, 5'd0));
    addr_pool.delete();
    for (n = 0; n < 40; n++) begin
      a = fresh_addr();
      addr_pool.push_back(a);
      reqs_to_send.push_back(make_req(FuncUpsert, a, SigW'($urandom_range(0, 255)), 5'd0));
      if (n % 4 == 3) begin
        reqs_to_send.push_back(make_req(FuncQuery, '0, '0, QidxW'($urandom_range(0, 31))));
      end
    end
    reqs_to_send.push_back(make_req(FuncQuery, '0, '0, 5'd31));
    for (n = 0; n < 30; n++) reqs_to_send.push_back(random_item(40));

    // long receiver hold-off while requests keep coming
    wait_drained();
    long_hold_req = 1'b1;
    for (n = 0; n < 30; n++) reqs_to_send.push_back(random_item(48));

    // sender pause until all responses are in, then back-to-back traffic
    wait_drained();
    repeat ($urandom_range(5, 20)) @(posedge clk_i);
    steady_flow = 1'b1;
    for (n = 0; n < 80; n++) reqs_to_send.push_back(random_item(48));
    wait_drained();
    steady_flow = 1'b0;
    addr_pool.delete();
    for (n = 0; n < 80; n++) reqs_to_send.push_back(random_item(10));

    wait_drained();
    repeat (Entries + 8) @(posedge clk_i);
    if (table_results_due.size() != 0) begin
      error_count++;
      $display("%0t: responses outstanding at the end: expected 0, actual %0d",
               $time, table_results_due.size());
    end
    $display("covered %0d request transfers and %0d checked responses, with %0d query hits",
             reqs_taken, results_checked, query_hits);
    $display("and %0d upserts dropped on a full table, %0d mismatches",
             full_drops, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
